// File: hdl/tccd_pkg.sv
// Shared types and constants of the terminal control code decoder.
`default_nettype none

package tccd_pkg;

	localparam int SCREEN_ROWS = 24;
	localparam int SCREEN_COLS = 80;

	localparam logic [4:0] LAST_ROW = 5'(SCREEN_ROWS - 1);
	localparam logic [6:0] LAST_COL = 7'(SCREEN_COLS - 1);

	typedef enum logic [2:0] {
		ACT_SHOW_CHAR   = 3'd0,
		ACT_SET_CURSOR  = 3'd1,
		ACT_CLEAR_UNPROT = 3'd2,
		ACT_CLEAR_ALL   = 3'd3,
		ACT_BELL        = 3'd4,
		ACT_SET_TYPE    = 3'd5
	} action_t;

	typedef struct packed {
		logic [7:0] host_byte;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} host_req_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] char_code;
		logic [4:0] new_row;
		logic [6:0] new_col;
		logic       last_of_run;
	} cmd_t;

	typedef struct packed {
		logic [1:0] count;
		cmd_t       first;
		cmd_t       second;
	} dec_res_t;

endpackage

`default_nettype wire

// File: hdl/tccd_decode.sv
// Byte decoder with cursor operand state; produces up to two commands per byte.
`default_nettype none

module tccd_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tccd_pkg::host_req_t req,
	input  wire logic                take,
	output tccd_pkg::dec_res_t       res
);

	localparam logic [7:0] B_HOME     = 8'd2;
	localparam logic [7:0] B_CLR_UNP  = 8'd6;
	localparam logic [7:0] B_BELL     = 8'd7;
	localparam logic [7:0] B_BKSP     = 8'd8;
	localparam logic [7:0] B_LF       = 8'd10;
	localparam logic [7:0] B_CLR_ALL  = 8'd12;
	localparam logic [7:0] B_CR       = 8'd13;
	localparam logic [7:0] B_POS      = 8'd16;
	localparam logic [7:0] B_UP       = 8'd23;
	localparam logic [7:0] B_RIGHT    = 8'd24;
	localparam logic [7:0] B_LEFT     = 8'd25;
	localparam logic [7:0] B_DOWN     = 8'd26;
	localparam logic [7:0] B_PROT_ON  = 8'd28;
	localparam logic [7:0] B_PROT_OFF = 8'd29;
	localparam logic [7:0] B_DEL      = 8'd127;
	localparam logic [7:0] B_PRINT    = 8'd32;

	logic [1:0] pending_q;
	logic [7:0] held_col_q;
	logic [1:0] pending_d;

	logic [4:0] r;
	logic [6:0] c;
	logic [7:0] b;
	logic [7:0] row_mod;
	logic [7:0] col_mod;

	function automatic logic [7:0] mod_const(input logic [7:0] v, input logic [8:0] m);
		logic [15:0] rem;
		logic [15:0] sh;
		rem = {8'd0, v};
		for (int i = 7; i >= 0; i--) begin
			sh = {7'd0, m} << i;
			if (rem >= sh) begin
				rem = rem - sh;
			end
		end
		return rem[7:0];
	endfunction

	function automatic tccd_pkg::cmd_t mk(input tccd_pkg::action_t a, input logic [7:0] code,
			input logic [4:0] row, input logic [6:0] col, input logic last);
		tccd_pkg::cmd_t t;
		t.action      = a;
		t.char_code   = code;
		t.new_row     = row;
		t.new_col     = col;
		t.last_of_run = last;
		return t;
	endfunction

	assign b       = req.host_byte;
	assign r       = (req.cursor_row > tccd_pkg::LAST_ROW) ? tccd_pkg::LAST_ROW : req.cursor_row;
	assign c       = (req.cursor_col > tccd_pkg::LAST_COL) ? tccd_pkg::LAST_COL : req.cursor_col;
	assign row_mod = mod_const(b, 9'(tccd_pkg::SCREEN_ROWS));
	assign col_mod = mod_const(held_col_q, 9'(tccd_pkg::SCREEN_COLS));

	always_comb begin
		res.count  = 2'd0;
		res.first  = mk(tccd_pkg::ACT_SHOW_CHAR, 8'd0, 5'd0, 7'd0, 1'b1);
		res.second = mk(tccd_pkg::ACT_SHOW_CHAR, 8'd0, 5'd0, 7'd0, 1'b1);
		pending_d  = 2'd0;
		if (pending_q >= 2'd2) begin
			pending_d = 2'd1;
		end else if (pending_q == 2'd1) begin
			res.count = 2'd1;
			res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0, row_mod[4:0], col_mod[6:0], 1'b1);
		end else if (b >= B_PRINT) begin
			if (b != B_DEL) begin
				res.count = 2'd1;
				res.first = mk(tccd_pkg::ACT_SHOW_CHAR, b, 5'd0, 7'd0, 1'b1);
			end
		end else begin
			res.count = 2'd1;
			case (b)
				B_HOME: begin
					res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0, 5'd0, 7'd0, 1'b1);
				end
				B_CLR_UNP: begin
					res.first = mk(tccd_pkg::ACT_CLEAR_UNPROT, 8'd0, 5'd0, 7'd0, 1'b1);
				end
				B_BELL: begin
					res.first = mk(tccd_pkg::ACT_BELL, 8'd0, 5'd0, 7'd0, 1'b1);
				end
				B_BKSP: begin
					res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0, r,
						(c == 7'd0) ? 7'd0 : c - 7'd1, 1'b1);
				end
				B_LF: begin
					res.count  = 2'd2;
					res.first  = mk(tccd_pkg::ACT_SHOW_CHAR, B_LF, 5'd0, 7'd0, 1'b0);
					res.second = mk(tccd_pkg::ACT_SHOW_CHAR, B_CR, 5'd0, 7'd0, 1'b1);
				end
				B_CLR_ALL: begin
					res.first = mk(tccd_pkg::ACT_CLEAR_ALL, 8'd0, 5'd0, 7'd0, 1'b1);
				end
				B_CR: begin
					res.first = mk(tccd_pkg::ACT_SHOW_CHAR, B_CR, 5'd0, 7'd0, 1'b1);
				end
				B_POS: begin
					res.count = 2'd0;
					pending_d = 2'd2;
				end
				B_UP: begin
					res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0,
						(r == 5'd0) ? tccd_pkg::LAST_ROW : r - 5'd1, c, 1'b1);
				end
				B_RIGHT: begin
					if (c >= tccd_pkg::LAST_COL) begin
						res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0,
							(r >= tccd_pkg::LAST_ROW) ? 5'd0 : r + 5'd1, 7'd0, 1'b1);
					end else begin
						res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0, r, c + 7'd1, 1'b1);
					end
				end
				B_LEFT: begin
					if (c == 7'd0) begin
						res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0,
							(r == 5'd0) ? tccd_pkg::LAST_ROW : r - 5'd1,
							tccd_pkg::LAST_COL, 1'b1);
					end else begin
						res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0, r, c - 7'd1, 1'b1);
					end
				end
				B_DOWN: begin
					res.first = mk(tccd_pkg::ACT_SET_CURSOR, 8'd0,
						(r >= tccd_pkg::LAST_ROW) ? 5'd0 : r + 5'd1, c, 1'b1);
				end
				B_PROT_ON, B_PROT_OFF: begin
					res.first = mk(tccd_pkg::ACT_SET_TYPE, b, 5'd0, 7'd0, 1'b1);
				end
				default: begin
					res.count = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 2'd0;
			held_col_q <= 8'd0;
		end else if (take) begin
			pending_q <= pending_d;
			if (pending_q >= 2'd2) begin
				held_col_q <= b;
			end
		end
	end

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("operand counter left its range");

	a_pos_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take && pending_q == 2'd0 && b == B_POS |=> pending_q == 2'd2)
		else $error("position byte did not arm the operand counter");

	a_column_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 |-> res.count == 2'd0)
		else $error("column operand produced a command");

	a_pair_marks: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> !res.first.last_of_run && res.second.last_of_run)
		else $error("two-command run marked wrongly");

endmodule

`default_nettype wire

// File: hdl/tccd_cmd_fifo.sv
// Three-entry command queue that takes up to two commands per cycle.
`default_nettype none

module tccd_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     push_n,
	input  wire tccd_pkg::cmd_t push_first,
	input  wire tccd_pkg::cmd_t push_second,
	output logic                space,
	output logic                cmd_valid,
	input  wire logic           cmd_ready,
	output tccd_pkg::cmd_t      cmd
);

	tccd_pkg::cmd_t entry_q [3];
	logic [1:0] cnt_q;
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic       pop;

	function automatic logic [1:0] inc3(input logic [1:0] p);
		return (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	assign space     = cnt_q <= 2'd1;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = entry_q[rd_q];
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_q] <= push_first;
		end
		if (push_n == 2'd2) begin
			entry_q[inc3(wr_q)] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
			wr_q  <= 2'd0;
		end else begin
			cnt_q <= cnt_q + push_n - {1'b0, pop};
			if (pop) begin
				rd_q <= inc3(rd_q);
			end
			if (push_n == 2'd1) begin
				wr_q <= inc3(wr_q);
			end else if (push_n == 2'd2) begin
				wr_q <= inc3(inc3(wr_q));
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> cnt_q <= 2'd1)
		else $error("command queue pushed without room");

	a_push_code: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two commands pushed");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd0 && !pop |=> $stable(cnt_q))
		else $error("queue fill changed while idle");

endmodule

`default_nettype wire

// File: hdl/terminal_control_code_decoder.sv
// Top level of the terminal control code decoder.
// Usage:
//   The host channel (host_valid, host_ready, host_req) carries one request per
//   host byte together with the cursor row and column read back from the display.
//   The command channel (cmd_valid, cmd_ready, cmd) carries display commands.
//   A request is registered in the input stage at acceptance, decoded there and
//   written into a three-entry command queue once the queue has room, so the first
//   command of a byte passes the input stage register and then the queue register.
//   Throughput is one byte per cycle while the receiver takes a command each
//   cycle; a line feed yields two commands and holds the host side, set by the
//   single command read port of the queue.
//   Cursor positioning consumes the following two bytes as operands; the column
//   byte yields no command and the row byte yields one set cursor command.
//   Reset clears the operand state and empties the queue and the input stage.
//   When the receiver stalls, commands wait in the queue and host_ready drops
//   once the queue holds two or more entries with a byte waiting in the stage.
`default_nettype none

module terminal_control_code_decoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                host_valid,
	output logic                     host_ready,
	input  wire tccd_pkg::host_req_t host_req,
	output logic                     cmd_valid,
	input  wire logic                cmd_ready,
	output tccd_pkg::cmd_t           cmd
);

	logic                host_vld_s1;
	tccd_pkg::host_req_t host_s1;
	logic                space;
	logic                take;
	tccd_pkg::dec_res_t  res;
	logic [1:0]          push_n;

	assign take       = host_vld_s1 && space;
	assign host_ready = !host_vld_s1 || space;
	assign push_n     = take ? res.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_vld_s1 <= 1'b0;
		end else if (host_ready) begin
			host_vld_s1 <= host_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (host_valid && host_ready) begin
			host_s1 <= host_req;
		end
	end

	tccd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (host_s1),
		.take   (take),
		.res    (res)
	);

	tccd_cmd_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.push_first  (res.first),
		.push_second (res.second),
		.space       (space),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

endmodule

`default_nettype wire
